/* sv/crarc_pkg.sv */
// ----------------------------------------------------------------------------
// crarc_pkg: shared definitions for the Catmull-Rom arc-length follower
// Field structs, command and status codes, widths and the controller to
// datapath command/status structs.
// ----------------------------------------------------------------------------
package crarc_pkg;

  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;
  localparam int ONE        = 1 << FRAC_BITS;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  localparam int STEP_W     = 11;
  localparam int STEP_RESET = 100;
  localparam int STEP_MAX   = 1024;

  // Parameter t lives in [-4, 4) and the cubic terms in a wider signed word.
  localparam int T_W  = FRAC_BITS + 3;
  localparam int W_W  = FRAC_BITS + 10;
  localparam int T_HI = 4 * ONE - 1;
  localparam int T_LO_MAG = 4 * ONE;

  // Shared multiplier operands and accumulator.
  localparam int MUL_W = 33;
  localparam int ACC_W = 64;

  // Divider: up to a 33-bit magnitude scaled by one, over a 32-bit divisor.
  localparam int DIV_NUM_W = FRAC_BITS + 33;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Square root of a 64-bit sum of squares.
  localparam int SQ_RAD_W  = 64;
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W + 1);

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_POS  = 2'd1;
  localparam logic [1:0] CMD_TAN  = 2'd2;

  localparam logic [1:0] ST_FOLLOW   = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
    logic signed [31:0] travel_distance;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [1:0]         path_status;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_PT_WRITE, OP_PT_READ, OP_PT_LATCH, OP_PREV,
    OP_DIV_SAMPLE, OP_DIV_QUERY, OP_T_SAMPLE, OP_T_QUERY, OP_T_ZERO,
    OP_MUL, OP_TT, OP_TTT, OP_WEIGHTS, OP_ACC_FRAC, OP_RES, OP_ABS,
    OP_ACC_RAW, OP_SQRT, OP_CHORD, OP_TOTAL_CLR, OP_CUM_WRITE, OP_CUM_READ,
    OP_SCAN, OP_OUT, OP_OUT_SHORT
  } op_t;

  typedef enum logic [2:0] {MS_TT, MS_TTT, MS_PW, MS_SQX, MS_SQY} mul_sel_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        sel;
    logic              axis;
    mul_sel_t          msel;
    logic              tangent;
    logic [STEP_W-1:0] k;
    logic [1:0]        status;
  } dp_cmd_t;

  typedef struct packed {
    logic              div_busy;
    logic              sqrt_busy;
    logic              ge;
    logic              len_zero;
    logic              out_free;
    logic [STEP_W-1:0] steps;
  } dp_stat_t;

endpackage

/* sv/crarc_div.sv */
// ----------------------------------------------------------------------------
// crarc_div: unsigned restoring divider
// One quotient bit per cycle; busy drops when the quotient is final.
// ----------------------------------------------------------------------------
module crarc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [crarc_pkg::DIV_NUM_W-1:0]    num,
  input  logic [crarc_pkg::DIV_DEN_W-1:0]    den,
  output logic                               busy,
  output logic [crarc_pkg::DIV_NUM_W-1:0]    quo
);

  logic [crarc_pkg::DIV_NUM_W-1:0] q;
  logic [crarc_pkg::DIV_DEN_W-1:0] rem;
  logic [crarc_pkg::DIV_DEN_W-1:0] dv;
  logic [crarc_pkg::DIV_CNT_W-1:0] cnt;
  logic [crarc_pkg::DIV_DEN_W:0]   rs;

  assign rs  = {rem, q[crarc_pkg::DIV_NUM_W-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= crarc_pkg::DIV_CNT_W'(crarc_pkg::DIV_NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == crarc_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      if (rs >= {1'b0, dv}) begin
        rem <= crarc_pkg::DIV_DEN_W'(rs - {1'b0, dv});
        q   <= {q[crarc_pkg::DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= rs[crarc_pkg::DIV_DEN_W-1:0];
        q   <= {q[crarc_pkg::DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/crarc_sqrt.sv */
// ----------------------------------------------------------------------------
// crarc_sqrt: integer square root
// Digit-by-digit floor root, one root bit per cycle.
// ----------------------------------------------------------------------------
module crarc_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [crarc_pkg::SQ_RAD_W-1:0]    rad,
  output logic                              busy,
  output logic [crarc_pkg::SQ_ROOT_W-1:0]   root
);

  logic [crarc_pkg::SQ_RAD_W-1:0]    r;
  logic [crarc_pkg::SQ_ROOT_W+1:0]   rem;
  logic [crarc_pkg::SQ_ROOT_W+3:0]   rs;
  logic [crarc_pkg::SQ_ROOT_W+3:0]   trial;
  logic [crarc_pkg::SQ_CNT_W-1:0]    cnt;

  assign rs    = {rem, r[crarc_pkg::SQ_RAD_W-1:crarc_pkg::SQ_RAD_W-2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= crarc_pkg::SQ_CNT_W'(crarc_pkg::SQ_ROOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == crarc_pkg::SQ_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r    <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      r <= r << 2;
      if (rs >= trial) begin
        rem  <= (crarc_pkg::SQ_ROOT_W+2)'(rs - trial);
        root <= {root[crarc_pkg::SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rs[crarc_pkg::SQ_ROOT_W+1:0];
        root <= {root[crarc_pkg::SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/crarc_dp.sv */
// ----------------------------------------------------------------------------
// crarc_dp: follower datapath
// Point and length memories, shared multiplier, divider and root units,
// curve evaluation registers and the result register.
// ----------------------------------------------------------------------------
module crarc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  crarc_pkg::dp_cmd_t                  cmd,
  output crarc_pkg::dp_stat_t                 stat,
  input  crarc_pkg::req_t                     req,
  input  logic                                cfg_valid,
  input  logic [crarc_pkg::STEP_W-1:0]        cfg_step_count,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output crarc_pkg::rsp_t                     rsp
);

  localparam int MW = crarc_pkg::MUL_W;
  localparam int WW = crarc_pkg::W_W;
  localparam int TW = crarc_pkg::T_W;
  localparam int NW = crarc_pkg::DIV_NUM_W;

  logic [63:0] pmem [crarc_pkg::MAX_POINTS];
  logic [31:0] cmem [crarc_pkg::MAX_POINTS];
  logic [63:0] prd;
  logic [31:0] crd;

  logic signed [31:0] px [4];
  logic signed [31:0] py [4];
  logic signed [WW-1:0] w [4];
  logic signed [31:0] pt_x_in, pt_y_in, qdist;
  logic signed [31:0] prev_x, prev_y, cur_x, cur_y;
  logic signed [TW-1:0] t;
  logic signed [WW-1:0] tt, ttt;
  logic signed [2*MW-1:0] prod;
  logic signed [2*MW-1:0] prod_frac;
  logic signed [crarc_pkg::ACC_W-1:0] acc;
  logic signed [crarc_pkg::ACC_W-1:0] half;
  logic signed [31:0] res_sat;
  logic [31:0] ax, ay;
  logic        dbl;
  logic [31:0] total, lo, hi;
  logic        neg;
  logic [crarc_pkg::STEP_W-1:0] step_count, steps;

  logic signed [MW-1:0] ma, mb;
  logic signed [32:0] dxs, dys, dq;
  logic [32:0] ax33, ay33, qmag;
  logic        big;
  logic [32:0] chord;
  logic [33:0] tsum;
  logic signed [WW-1:0] te, one_w;
  logic signed [WW-1:0] wn [4];

  logic              div_start, div_busy;
  logic [NW-1:0]     div_num, div_quo;
  logic [31:0]       div_den;
  logic              sq_busy;
  logic [31:0]       sq_root;

  // Step count clamp: zero acts as one, large values act as the maximum.
  always_comb begin
    if (step_count == '0) begin
      steps = crarc_pkg::STEP_W'(1);
    end else if (step_count > crarc_pkg::STEP_W'(crarc_pkg::STEP_MAX)) begin
      steps = crarc_pkg::STEP_W'(crarc_pkg::STEP_MAX);
    end else begin
      steps = step_count;
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    case (cmd.msel)
      crarc_pkg::MS_TT: begin
        ma = MW'(t);
        mb = MW'(t);
      end
      crarc_pkg::MS_TTT: begin
        ma = MW'(tt);
        mb = MW'(t);
      end
      crarc_pkg::MS_PW: begin
        ma = cmd.axis ? MW'(py[cmd.sel]) : MW'(px[cmd.sel]);
        mb = MW'(w[cmd.sel]);
      end
      crarc_pkg::MS_SQX: begin
        ma = $signed({1'b0, ax});
        mb = $signed({1'b0, ax});
      end
      crarc_pkg::MS_SQY: begin
        ma = $signed({1'b0, ay});
        mb = $signed({1'b0, ay});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Weights are the basis polynomials doubled.
  assign te    = WW'(t);
  assign one_w = WW'(crarc_pkg::ONE);
  always_comb begin
    if (cmd.tangent) begin
      wn[0] = WW'(-one_w + 4 * te - 3 * tt);
      wn[1] = WW'(-10 * te + 9 * tt);
      wn[2] = WW'(one_w + 8 * te - 9 * tt);
      wn[3] = WW'(-2 * te + 3 * tt);
    end else begin
      wn[0] = WW'(-ttt + 2 * tt - te);
      wn[1] = WW'(3 * ttt - 5 * tt + 2 * one_w);
      wn[2] = WW'(-3 * ttt + 4 * tt + te);
      wn[3] = WW'(ttt - tt);
    end
  end

  assign prod_frac = prod >>> crarc_pkg::FRAC_BITS;
  assign half      = acc >>> 1;
  always_comb begin
    if (half > 64'sh7FFF_FFFF) begin
      res_sat = 32'sh7FFF_FFFF;
    end else if (half < -64'sh8000_0000) begin
      res_sat = -32'sh8000_0000;
    end else begin
      res_sat = half[31:0];
    end
  end

  assign dxs  = 33'(cur_x) - 33'(prev_x);
  assign dys  = 33'(cur_y) - 33'(prev_y);
  assign ax33 = dxs[32] ? 33'(-dxs) : 33'(dxs);
  assign ay33 = dys[32] ? 33'(-dys) : 33'(dys);
  assign big  = (|ax33[32:31]) | (|ay33[32:31]);

  assign chord = dbl ? {sq_root, 1'b0} : {1'b0, sq_root};
  assign tsum  = {2'b00, total} + {1'b0, chord};

  // Query numerator: distance past the previous total, as sign and magnitude.
  assign dq   = 33'(qdist) - $signed({1'b0, lo});
  assign qmag = dq[32] ? 33'(-dq) : 33'(dq);

  assign div_start = (cmd.op == crarc_pkg::OP_DIV_SAMPLE) ||
                     (cmd.op == crarc_pkg::OP_DIV_QUERY);
  always_comb begin
    if (cmd.op == crarc_pkg::OP_DIV_QUERY) begin
      div_num = NW'(qmag) << crarc_pkg::FRAC_BITS;
      div_den = hi - lo;
    end else begin
      div_num = NW'(cmd.k) << crarc_pkg::FRAC_BITS;
      div_den = 32'(steps);
    end
  end

  crarc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  crarc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == crarc_pkg::OP_SQRT),
    .rad   (acc),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == crarc_pkg::OP_PT_WRITE) begin
      pmem[cmd.addr] <= {pt_y_in, pt_x_in};
    end
    if (cmd.op == crarc_pkg::OP_PT_READ) begin
      prd <= pmem[cmd.addr];
    end
    if (cmd.op == crarc_pkg::OP_CUM_WRITE) begin
      cmem[cmd.addr] <= total;
    end
    if (cmd.op == crarc_pkg::OP_CUM_READ) begin
      crd <= cmem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      crarc_pkg::OP_CAPTURE: begin
        pt_x_in <= req.point_x;
        pt_y_in <= req.point_y;
        qdist   <= req.travel_distance;
        hi      <= '0;
        lo      <= '0;
      end
      crarc_pkg::OP_PT_LATCH: begin
        px[cmd.sel] <= prd[31:0];
        py[cmd.sel] <= prd[63:32];
      end
      crarc_pkg::OP_PREV: begin
        prev_x <= px[1];
        prev_y <= py[1];
      end
      crarc_pkg::OP_DIV_QUERY: begin
        neg <= dq[32];
      end
      crarc_pkg::OP_T_SAMPLE: begin
        t <= $signed(div_quo[TW-1:0]);
      end
      crarc_pkg::OP_T_QUERY: begin
        if (!neg) begin
          if (div_quo > NW'(crarc_pkg::T_HI)) begin
            t <= TW'(crarc_pkg::T_HI);
          end else begin
            t <= $signed(div_quo[TW-1:0]);
          end
        end else begin
          if (div_quo > NW'(crarc_pkg::T_LO_MAG)) begin
            t <= -TW'(crarc_pkg::T_LO_MAG);
          end else begin
            t <= -$signed(div_quo[TW-1:0]);
          end
        end
      end
      crarc_pkg::OP_T_ZERO: begin
        t <= '0;
      end
      crarc_pkg::OP_MUL: begin
        prod <= ma * mb;
      end
      crarc_pkg::OP_TT: begin
        tt <= prod_frac[WW-1:0];
      end
      crarc_pkg::OP_TTT: begin
        ttt <= prod_frac[WW-1:0];
      end
      crarc_pkg::OP_WEIGHTS: begin
        for (int i = 0; i < 4; i++) begin
          w[i] <= wn[i];
        end
        acc <= '0;
      end
      crarc_pkg::OP_ACC_FRAC: begin
        acc <= acc + prod_frac[crarc_pkg::ACC_W-1:0];
      end
      crarc_pkg::OP_RES: begin
        if (cmd.axis) begin
          cur_y <= res_sat;
        end else begin
          cur_x <= res_sat;
        end
        acc <= '0;
      end
      crarc_pkg::OP_ABS: begin
        ax  <= big ? ax33[32:1] : ax33[31:0];
        ay  <= big ? ay33[32:1] : ay33[31:0];
        dbl <= big;
        acc <= '0;
      end
      crarc_pkg::OP_ACC_RAW: begin
        acc <= acc + prod[crarc_pkg::ACC_W-1:0];
      end
      crarc_pkg::OP_CHORD: begin
        total  <= (tsum > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : tsum[31:0];
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      crarc_pkg::OP_TOTAL_CLR: begin
        total <= '0;
      end
      crarc_pkg::OP_SCAN: begin
        lo <= hi;
        hi <= crd;
      end
      default: begin
      end
    endcase
  end

  // Result register and the step count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      step_count <= crarc_pkg::STEP_W'(crarc_pkg::STEP_RESET);
    end else begin
      if (cfg_valid) begin
        step_count <= cfg_step_count;
      end
      if (cmd.op == crarc_pkg::OP_OUT || cmd.op == crarc_pkg::OP_OUT_SHORT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == crarc_pkg::OP_OUT) begin
      rsp <= '{out_x: cur_x, out_y: cur_y, path_status: cmd.status};
    end else if (cmd.op == crarc_pkg::OP_OUT_SHORT) begin
      rsp <= '{out_x: '0, out_y: '0, path_status: crarc_pkg::ST_SHORT};
    end
  end

  assign stat.div_busy  = div_busy;
  assign stat.sqrt_busy = sq_busy;
  assign stat.ge        = $signed({1'b0, hi}) >= 33'(qdist);
  assign stat.len_zero  = (hi == lo);
  assign stat.out_free  = !rsp_valid;
  assign stat.steps     = steps;

endmodule

/* sv/crarc_ctrl.sv */
// ----------------------------------------------------------------------------
// crarc_ctrl: follower sequencer
// Drives loads, segment length build, search and curve evaluation through
// the datapath command port.
// ----------------------------------------------------------------------------
module crarc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            req_command,
  input  logic                  req_last,
  output crarc_pkg::dp_cmd_t    cmd,
  input  crarc_pkg::dp_stat_t   stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_B_INIT, S_B_SEG, S_F_RD, S_F_LT, S_B_PREV, S_B_DIV,
    S_B_DIVW, S_EV_MTT, S_EV_TT, S_EV_MTTT, S_EV_TTT, S_EV_W, S_EV_MPW,
    S_EV_APW, S_EV_RES, S_CH_ABS, S_CH_MX, S_CH_AX, S_CH_MY, S_CH_AY,
    S_CH_SQ, S_CH_SQW, S_B_CUM, S_SC_RD, S_SC_SH, S_SC_CK, S_Q_DIV,
    S_Q_DIVW, S_Q_OUT, S_SHORT
  } state_t;

  state_t state, state_next;

  logic [crarc_pkg::CNT_W-1:0]  cnt, seg_total, s, sidx;
  logic [crarc_pkg::ADDR_W-1:0] idx, base;
  logic [crarc_pkg::STEP_W-1:0] k;
  logic [1:0] j, i4;
  logic       ax_sel, closed, is_query, tan_q, last_q;
  logic [1:0] qstat;
  logic       scan_last;

  assign base      = is_query ? idx : s[crarc_pkg::ADDR_W-1:0];
  assign scan_last = (sidx == seg_total - 1'b1);

  always_comb begin
    cmd         = '0;
    cmd.op      = crarc_pkg::OP_NONE;
    cmd.msel    = crarc_pkg::MS_TT;
    cmd.tangent = tan_q;
    cmd.k       = k;
    cmd.status  = qstat;
    cmd.sel     = i4;
    cmd.axis    = ax_sel;
    req_ready   = 1'b0;
    state_next  = state;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op = crarc_pkg::OP_CAPTURE;
          if (req_command == crarc_pkg::CMD_LOAD) begin
            state_next = S_LOAD;
          end else if (req_command == crarc_pkg::CMD_POS ||
                       req_command == crarc_pkg::CMD_TAN) begin
            state_next = (seg_total == '0) ? S_SHORT : S_SC_RD;
          end
        end
      end
      S_LOAD: begin
        if (cnt < crarc_pkg::CNT_W'(crarc_pkg::MAX_POINTS)) begin
          cmd.op   = crarc_pkg::OP_PT_WRITE;
          cmd.addr = cnt[crarc_pkg::ADDR_W-1:0];
        end
        state_next = last_q ? S_B_INIT : S_IDLE;
      end
      S_B_INIT: begin
        cmd.op     = crarc_pkg::OP_TOTAL_CLR;
        state_next = S_B_SEG;
      end
      S_B_SEG: begin
        state_next = (s == seg_total) ? S_IDLE : S_F_RD;
      end
      S_F_RD: begin
        cmd.op     = crarc_pkg::OP_PT_READ;
        cmd.addr   = base + crarc_pkg::ADDR_W'(j);
        state_next = S_F_LT;
      end
      S_F_LT: begin
        cmd.op  = crarc_pkg::OP_PT_LATCH;
        cmd.sel = j;
        if (j == 2'd3) begin
          state_next = is_query ? S_EV_MTT : S_B_PREV;
        end else begin
          state_next = S_F_RD;
        end
      end
      S_B_PREV: begin
        cmd.op     = crarc_pkg::OP_PREV;
        state_next = S_B_DIV;
      end
      S_B_DIV: begin
        cmd.op     = crarc_pkg::OP_DIV_SAMPLE;
        state_next = S_B_DIVW;
      end
      S_B_DIVW: begin
        if (!stat.div_busy) begin
          cmd.op     = crarc_pkg::OP_T_SAMPLE;
          state_next = S_EV_MTT;
        end
      end
      S_EV_MTT: begin
        cmd.op     = crarc_pkg::OP_MUL;
        cmd.msel   = crarc_pkg::MS_TT;
        state_next = S_EV_TT;
      end
      S_EV_TT: begin
        cmd.op     = crarc_pkg::OP_TT;
        state_next = S_EV_MTTT;
      end
      S_EV_MTTT: begin
        cmd.op     = crarc_pkg::OP_MUL;
        cmd.msel   = crarc_pkg::MS_TTT;
        state_next = S_EV_TTT;
      end
      S_EV_TTT: begin
        cmd.op     = crarc_pkg::OP_TTT;
        state_next = S_EV_W;
      end
      S_EV_W: begin
        cmd.op     = crarc_pkg::OP_WEIGHTS;
        state_next = S_EV_MPW;
      end
      S_EV_MPW: begin
        cmd.op     = crarc_pkg::OP_MUL;
        cmd.msel   = crarc_pkg::MS_PW;
        state_next = S_EV_APW;
      end
      S_EV_APW: begin
        cmd.op     = crarc_pkg::OP_ACC_FRAC;
        state_next = (i4 == 2'd3) ? S_EV_RES : S_EV_MPW;
      end
      S_EV_RES: begin
        cmd.op = crarc_pkg::OP_RES;
        if (ax_sel) begin
          state_next = is_query ? S_Q_OUT : S_CH_ABS;
        end else begin
          state_next = S_EV_MPW;
        end
      end
      S_CH_ABS: begin
        cmd.op     = crarc_pkg::OP_ABS;
        state_next = S_CH_MX;
      end
      S_CH_MX: begin
        cmd.op     = crarc_pkg::OP_MUL;
        cmd.msel   = crarc_pkg::MS_SQX;
        state_next = S_CH_AX;
      end
      S_CH_AX: begin
        cmd.op     = crarc_pkg::OP_ACC_RAW;
        state_next = S_CH_MY;
      end
      S_CH_MY: begin
        cmd.op     = crarc_pkg::OP_MUL;
        cmd.msel   = crarc_pkg::MS_SQY;
        state_next = S_CH_AY;
      end
      S_CH_AY: begin
        cmd.op     = crarc_pkg::OP_ACC_RAW;
        state_next = S_CH_SQ;
      end
      S_CH_SQ: begin
        cmd.op     = crarc_pkg::OP_SQRT;
        state_next = S_CH_SQW;
      end
      S_CH_SQW: begin
        if (!stat.sqrt_busy) begin
          cmd.op     = crarc_pkg::OP_CHORD;
          state_next = (k == stat.steps) ? S_B_CUM : S_B_DIV;
        end
      end
      S_B_CUM: begin
        cmd.op     = crarc_pkg::OP_CUM_WRITE;
        cmd.addr   = s[crarc_pkg::ADDR_W-1:0];
        state_next = S_B_SEG;
      end
      S_SC_RD: begin
        cmd.op     = crarc_pkg::OP_CUM_READ;
        cmd.addr   = sidx[crarc_pkg::ADDR_W-1:0];
        state_next = S_SC_SH;
      end
      S_SC_SH: begin
        cmd.op     = crarc_pkg::OP_SCAN;
        state_next = S_SC_CK;
      end
      S_SC_CK: begin
        state_next = (stat.ge || scan_last) ? S_Q_DIV : S_SC_RD;
      end
      S_Q_DIV: begin
        if (stat.len_zero) begin
          cmd.op     = crarc_pkg::OP_T_ZERO;
          state_next = S_F_RD;
        end else begin
          cmd.op     = crarc_pkg::OP_DIV_QUERY;
          state_next = S_Q_DIVW;
        end
      end
      S_Q_DIVW: begin
        if (!stat.div_busy) begin
          cmd.op     = crarc_pkg::OP_T_QUERY;
          state_next = S_F_RD;
        end
      end
      S_Q_OUT: begin
        if (stat.out_free) begin
          cmd.op     = crarc_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      S_SHORT: begin
        if (stat.out_free) begin
          cmd.op     = crarc_pkg::OP_OUT_SHORT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      seg_total <= '0;
      closed    <= 1'b0;
      s         <= '0;
      sidx      <= '0;
      idx       <= '0;
      k         <= '0;
      j         <= '0;
      i4        <= '0;
      ax_sel    <= 1'b0;
      is_query  <= 1'b0;
      tan_q     <= 1'b0;
      last_q    <= 1'b0;
      qstat     <= crarc_pkg::ST_FOLLOW;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            tan_q    <= (req_command == crarc_pkg::CMD_TAN);
            last_q   <= req_last;
            is_query <= (req_command != crarc_pkg::CMD_LOAD);
            sidx     <= '0;
            if (req_command == crarc_pkg::CMD_LOAD && closed) begin
              cnt       <= '0;
              seg_total <= '0;
              closed    <= 1'b0;
            end
          end
        end
        S_LOAD: begin
          if (cnt < crarc_pkg::CNT_W'(crarc_pkg::MAX_POINTS)) begin
            cnt <= cnt + 1'b1;
          end
          if (last_q) begin
            closed <= 1'b1;
          end
        end
        S_B_INIT: begin
          seg_total <= (cnt >= crarc_pkg::CNT_W'(4)) ? cnt - crarc_pkg::CNT_W'(3) : '0;
          s         <= '0;
        end
        S_B_SEG: begin
          j <= '0;
        end
        S_F_LT: begin
          j <= j + 1'b1;
        end
        S_B_PREV: begin
          k <= '0;
        end
        S_EV_W: begin
          i4     <= '0;
          ax_sel <= 1'b0;
        end
        S_EV_APW: begin
          i4 <= i4 + 1'b1;
        end
        S_EV_RES: begin
          ax_sel <= ~ax_sel;
        end
        S_CH_SQW: begin
          if (!stat.sqrt_busy && k != stat.steps) begin
            k <= k + 1'b1;
          end
        end
        S_B_CUM: begin
          s <= s + 1'b1;
        end
        S_SC_CK: begin
          j <= '0;
          if (stat.ge) begin
            qstat <= crarc_pkg::ST_FOLLOW;
            idx   <= sidx[crarc_pkg::ADDR_W-1:0];
          end else if (scan_last) begin
            qstat <= crarc_pkg::ST_COMPLETE;
            idx   <= sidx[crarc_pkg::ADDR_W-1:0];
          end else begin
            sidx <= sidx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A result is written only into an empty result register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == crarc_pkg::OP_OUT || cmd.op == crarc_pkg::OP_OUT_SHORT) |-> stat.out_free)
    else $error("result written while result register is full");

  // The divider is never restarted while it is working.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == crarc_pkg::OP_DIV_SAMPLE || cmd.op == crarc_pkg::OP_DIV_QUERY)
      |-> !stat.div_busy)
    else $error("divider started while busy");

  // Built segments always match the number of stored points.
  a_seg_count: assert property (@(posedge clk) disable iff (rst)
    (seg_total != '0) |-> (cnt == seg_total + crarc_pkg::CNT_W'(3)))
    else $error("segment count out of step with point count");

  // A query with no segments answers through the short-path state.
  a_short: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && seg_total == '0 &&
     (req_command == crarc_pkg::CMD_POS || req_command == crarc_pkg::CMD_TAN))
      |=> state == S_SHORT)
    else $error("query without segments took the wrong path");

endmodule

/* sv/catmull_rom_arc_length_follower_core.sv */
// ----------------------------------------------------------------------------
// catmull_rom_arc_length_follower_core: Catmull-Rom arc-length path follower
// Loads a point sequence, measures each uniform Catmull-Rom segment by chord
// sums and answers distance queries with a position or tangent.
// ----------------------------------------------------------------------------
// The block works on one item at a time and takes a new item whenever its
// sequencer is idle, even while an earlier result still waits in the output
// register; a later query that finishes while that register is still full
// waits for it to empty. A load transfer stores its point, while the store
// has room, in the load state and then leaves the sequencer idle again. The
// transfer that carries the trailing control point instead goes on to build
// the length table: for each segment and each of the step_count+1 samples
// (step_count taken as 1 to 1024) the block divides for t on the 49-bit
// bit-serial divider, evaluates the curve on the shared multiplier and takes
// the chord from a 32-bit square root. A query reads the length table entry
// by entry until an entry reaches its distance or the last entry is read,
// then divides for t, evaluates the curve and loads its result register; a
// segment of zero length skips the division. The evaluation makes eight
// multiply-accumulate passes, four per axis. A query made while no segments
// exist goes to the short-path state, which loads its result register with
// status 2 and zero coordinates once that register is empty. The step_count
// register is taken when a load ends and may be written only while the block
// is idle.
// ----------------------------------------------------------------------------
module catmull_rom_arc_length_follower_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crarc_pkg::STEP_W-1:0]  cfg_step_count,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  crarc_pkg::req_t               req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output crarc_pkg::rsp_t               rsp
);

  crarc_pkg::dp_cmd_t  cmd;
  crarc_pkg::dp_stat_t stat;

  // The configuration register accepts a transfer in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer: owns the point count, segment count and all loop counters.
  crarc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_command (req.command),
    .req_last    (req.last_point),
    .cmd         (cmd),
    .stat        (stat)
  );

  // Datapath: memories, arithmetic units and the result register.
  crarc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req            (req),
    .cfg_valid      (cfg_valid),
    .cfg_step_count (cfg_step_count),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp)
  );

endmodule

/* tb/sv/catmull_rom_arc_length_follower_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_arc_length_follower_checker: result checker for the path follower
// Watches the configuration, request and response channels, keeps its own
// copy of the point store and length table, predicts every query answer and
// compares each response transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module catmull_rom_arc_length_follower_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [crarc_pkg::STEP_W-1:0] cfg_step_count,
  input  logic                         req_valid,
  input  logic                         req_ready,
  input  crarc_pkg::req_t              req,
  input  logic                         rsp_valid,
  input  logic                         rsp_ready,
  input  crarc_pkg::rsp_t              rsp,
  output int                           fail_count,
  output int                           pending,
  output int                           answered
);

  longint                       pt_x [crarc_pkg::MAX_POINTS];
  longint                       pt_y [crarc_pkg::MAX_POINTS];
  longint                       seg_end_len [crarc_pkg::MAX_POINTS];
  int                           pts_held;
  int                           segs_built;
  bit                           path_closed;
  logic [crarc_pkg::STEP_W-1:0] sample_steps;
  crarc_pkg::rsp_t              answer_q [$];
  int                           errors;
  int                           checked;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Position or tangent of segment seg at parameter t, both axes doubled
  // weights summed and then halved.
  function automatic void curve_at(input int seg, input longint t, input bit tangent,
                                   output longint cx, output longint cy);
    longint tt, ttt, sx, sy;
    longint w [4];
    tt  = (t * t) >>> crarc_pkg::FRAC_BITS;
    ttt = (tt * t) >>> crarc_pkg::FRAC_BITS;
    if (tangent) begin
      w[0] = -crarc_pkg::ONE + 4 * t - 3 * tt;
      w[1] = -10 * t + 9 * tt;
      w[2] = crarc_pkg::ONE + 8 * t - 9 * tt;
      w[3] = -2 * t + 3 * tt;
    end else begin
      w[0] = -ttt + 2 * tt - t;
      w[1] = 3 * ttt - 5 * tt + 2 * crarc_pkg::ONE;
      w[2] = -3 * ttt + 4 * tt + t;
      w[3] = ttt - tt;
    end
    sx = 0;
    sy = 0;
    for (int i = 0; i < 4; i++) begin
      sx += (pt_x[seg + i] * w[i]) >>> crarc_pkg::FRAC_BITS;
      sy += (pt_y[seg + i] * w[i]) >>> crarc_pkg::FRAC_BITS;
    end
    cx = clamp32(sx >>> 1);
    cy = clamp32(sy >>> 1);
  endfunction

  function automatic longint unsigned int_root(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint chord_len(input longint dx, input longint dy);
    longint unsigned ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if ((ax >> 31) != 0 || (ay >> 31) != 0) begin
      ax >>= 1;
      ay >>= 1;
      return longint'(int_root(ax * ax + ay * ay) << 1);
    end
    return longint'(int_root(ax * ax + ay * ay));
  endfunction

  // Runs when the trailing control point closes the sequence.
  function automatic void measure_path();
    longint total, t, px0, py0, cx, cy;
    int steps;
    steps = int'(sample_steps);
    if (steps < 1) steps = 1;
    if (steps > crarc_pkg::STEP_MAX) steps = crarc_pkg::STEP_MAX;
    total = 0;
    segs_built = pts_held >= 4 ? pts_held - 3 : 0;
    for (int s = 0; s < segs_built; s++) begin
      px0 = pt_x[s + 1];
      py0 = pt_y[s + 1];
      for (int k = 0; k <= steps; k++) begin
        t = (longint'(k) * crarc_pkg::ONE) / steps;
        curve_at(s, t, 1'b0, cx, cy);
        total += chord_len(cx - px0, cy - py0);
        if (total > 64'sh7FFFFFFF) total = 64'sh7FFFFFFF;
        px0 = cx;
        py0 = cy;
      end
      seg_end_len[s] = total;
    end
  endfunction

  function automatic crarc_pkg::rsp_t answer_query(input logic [1:0] cmd, input longint d);
    crarc_pkg::rsp_t a;
    int idx;
    longint base_len, len, t, cx, cy;
    a = '0;
    if (segs_built == 0) begin
      a.path_status = crarc_pkg::ST_SHORT;
      return a;
    end
    idx = segs_built - 1;
    a.path_status = crarc_pkg::ST_COMPLETE;
    for (int i = 0; i < segs_built; i++) begin
      if (seg_end_len[i] >= d) begin
        idx = i;
        a.path_status = crarc_pkg::ST_FOLLOW;
        break;
      end
    end
    base_len = idx == 0 ? 0 : seg_end_len[idx - 1];
    len = seg_end_len[idx] - base_len;
    t = len > 0 ? ((d - base_len) * crarc_pkg::ONE) / len : 0;
    if (t < -crarc_pkg::T_LO_MAG) t = -crarc_pkg::T_LO_MAG;
    if (t > crarc_pkg::T_HI) t = crarc_pkg::T_HI;
    curve_at(idx, t, cmd == crarc_pkg::CMD_TAN, cx, cy);
    a.out_x = cx[31:0];
    a.out_y = cy[31:0];
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pts_held = 0;
      segs_built = 0;
      path_closed = 1'b0;
      sample_steps = crarc_pkg::STEP_W'(crarc_pkg::STEP_RESET);
      answer_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response: x=%0d y=%0d status=%0d",
                     rsp.out_x, rsp.out_y, rsp.path_status);
        end else begin
          crarc_pkg::rsp_t want;
          want = answer_q.pop_front();
          checked++;
          if (rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
              rsp.path_status !== want.path_status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                       want.out_x, want.out_y, want.path_status,
                       rsp.out_x, rsp.out_y, rsp.path_status);
          end
        end
      end
      if (cfg_valid && cfg_ready) sample_steps = cfg_step_count;
      if (req_valid && req_ready) begin
        if (req.command == crarc_pkg::CMD_LOAD) begin
          // A load after a closed sequence starts a fresh path.
          if (path_closed) begin
            pts_held = 0;
            segs_built = 0;
            path_closed = 1'b0;
          end
          if (pts_held < crarc_pkg::MAX_POINTS) begin
            pt_x[pts_held] = longint'(req.point_x);
            pt_y[pts_held] = longint'(req.point_y);
            pts_held++;
          end
          if (req.last_point) begin
            path_closed = 1'b1;
            measure_path();
          end
        end else if (req.command == crarc_pkg::CMD_POS ||
                     req.command == crarc_pkg::CMD_TAN) begin
          answer_q.insert(answer_q.size(),
                          answer_query(req.command, longint'(req.travel_distance)));
        end
      end
    end
    fail_count <= errors;
    pending <= answer_q.size();
    answered <= checked;
  end

endmodule

/* tb/sv/catmull_rom_arc_length_follower_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_arc_length_follower_core_test: top of the path follower bench
// Drives point loads, position and tangent queries and step_count writes with
// random idling on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module catmull_rom_arc_length_follower_core_test;

  // The fourth command code is unused; the block must drop it silently.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                         clk;
  logic                         rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [crarc_pkg::STEP_W-1:0] cfg_step_count;
  logic                         req_valid;
  logic                         req_ready;
  crarc_pkg::req_t              req;
  logic                         rsp_valid;
  logic                         rsp_ready;
  crarc_pkg::rsp_t              rsp;

  int fail_count;
  int pending;
  int answered;

  // Idle and stall odds in percent, changed per phase.
  int idle_pct;
  int stall_pct;

  int items_sent;
  int loads_closed;
  int settings_used;

  // Scale and size of the path most recently loaded, used to aim queries.
  int path_scale;
  int path_pts;

  catmull_rom_arc_length_follower_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_step_count (cfg_step_count),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp)
  );

  catmull_rom_arc_length_follower_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_step_count (cfg_step_count),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .fail_count     (fail_count),
    .pending        (pending),
    .answered       (answered)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The receiver stalls at random; with stall_pct at zero it never does.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop well beyond the slowest correct run, including the long builds
  // at the largest step count.
  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic crarc_pkg::req_t make_req(input logic [1:0] cmd,
                                               input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input logic last,
                                               input logic signed [31:0] d);
    crarc_pkg::req_t r;
    r.command = cmd;
    r.point_x = x;
    r.point_y = y;
    r.last_point = last;
    r.travel_distance = d;
    return r;
  endfunction

  // A coordinate spread over plus or minus 2^scale; scale 31 covers the
  // whole signed range.
  function automatic logic signed [31:0] rand_coord(input int scale);
    longint span;
    span = longint'(1) << scale;
    return 32'(longint'($urandom) % (2 * span) - span);
  endfunction

  // One request transfer. Idle cycles come before the item, so valid is
  // never lowered and raised in the same step, and it holds until accepted.
  task automatic send_item(input crarc_pkg::req_t item);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (item.command != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_point(input int scale, input logic last);
    send_item(make_req(crarc_pkg::CMD_LOAD, rand_coord(scale), rand_coord(scale), last,
                       $urandom));
  endtask

  // Queries mostly land inside the path length, a few before its start or
  // past its end, and a tenth use any distance at all.
  task automatic send_query();
    longint reach, d;
    logic [1:0] cmd;
    cmd = $urandom_range(1) ? crarc_pkg::CMD_TAN : crarc_pkg::CMD_POS;
    reach = longint'(path_pts + 1) * (longint'(3) << path_scale);
    if ($urandom_range(9) == 0) d = longint'(signed'($urandom));
    else d = longint'($urandom) % (reach + 1) - reach / 16;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    send_item(make_req(cmd, rand_coord(31), rand_coord(31), 1'($urandom_range(1)),
                       32'(d)));
  endtask

  task automatic load_path(input int npts, input int scale);
    for (int i = 0; i < npts; i++) send_point(scale, i == npts - 1);
    path_pts = npts;
    path_scale = scale;
    loads_closed++;
  endtask

  // The block may still be building the length table after a load, which
  // produces no response. A query cannot be answered before the build is
  // done, so once its answer is back the block is idle.
  task automatic wait_idle();
    send_query();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_steps(input logic [crarc_pkg::STEP_W-1:0] steps);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_step_count <= steps;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random traffic: mostly complete paths followed by queries, with partial
  // loads, too-short paths, unused commands and stray queries mixed in.
  task automatic run_traffic(input int quota, input bit with_full_store);
    int pick, start;
    bit full_done;
    start = items_sent;
    full_done = 1'b0;
    while (items_sent - start < quota) begin
      pick = $urandom_range(99);
      if (with_full_store && !full_done) begin
        // Overfill the store; the extra points are dropped.
        full_done = 1'b1;
        load_path($urandom_range(crarc_pkg::MAX_POINTS + 2, crarc_pkg::MAX_POINTS + 6),
                  $urandom_range(8, 24));
        repeat ($urandom_range(4, 12)) send_query();
      end else if (pick < 70) begin
        load_path($urandom_range(4, 7), $urandom_range(4, 31));
        repeat ($urandom_range(2, 10)) send_query();
      end else if (pick < 80) begin
        // Queries made while a load is still open see no segments.
        repeat ($urandom_range(1, 3)) send_point($urandom_range(4, 31), 1'b0);
        repeat ($urandom_range(1, 3)) send_query();
      end else if (pick < 88) begin
        load_path($urandom_range(1, 3), $urandom_range(4, 31));
        repeat ($urandom_range(1, 3)) send_query();
      end else if (pick < 94) begin
        send_item(make_req(CMD_UNUSED, rand_coord(31), rand_coord(31),
                           1'($urandom_range(1)), $urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_query();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_step_count = '0;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    loads_closed = 0;
    settings_used = 0;
    path_scale = 16;
    path_pts = 4;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset step count. Queries before any path, and
    // an unused command.
    send_item(make_req(crarc_pkg::CMD_POS, 32'sd0, 32'sd0, 1'b0, 32'sd0));
    send_item(make_req(CMD_UNUSED, 32'sh7FFFFFFF, 32'sh80000000, 1'b1, 32'sh7FFFFFFF));
    send_item(make_req(crarc_pkg::CMD_TAN, 32'sh80000000, 32'sh7FFFFFFF, 1'b1,
                       32'sh80000000));
    // Four identical points: the single segment has zero length, so t is zero.
    for (int i = 0; i < 4; i++)
      send_item(make_req(crarc_pkg::CMD_LOAD, 32'sd5 <<< 16, -(32'sd3 <<< 16), i == 3,
                         32'sd0));
    send_item(make_req(crarc_pkg::CMD_POS, 32'sd0, 32'sd0, 1'b0, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_TAN, 32'sd0, 32'sd0, 1'b0, 32'sd100));
    // Corner points: saturated curve values, halved chords, clipped totals.
    send_item(make_req(crarc_pkg::CMD_LOAD, 32'sh80000000, 32'sh7FFFFFFF, 1'b0, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_LOAD, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_LOAD, 32'sh80000000, 32'sh80000000, 1'b0, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_LOAD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_POS, 32'sd0, 32'sd0, 1'b0, 32'sh80000000));
    send_item(make_req(crarc_pkg::CMD_POS, 32'sd0, 32'sd0, 1'b0, 32'sh7FFFFFFF));
    send_item(make_req(crarc_pkg::CMD_TAN, 32'sd0, 32'sd0, 1'b0, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_POS, 32'sd0, 32'sd0, 1'b0, 32'sd1 <<< 16));
    send_item(make_req(crarc_pkg::CMD_TAN, 32'sd0, 32'sd0, 1'b0, 32'sh7FFFFFFF));
    // An ordinary small curve, queried inside and before its start.
    send_item(make_req(crarc_pkg::CMD_LOAD, 32'sd0, 32'sd0, 1'b0, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_LOAD, 32'sd1 <<< 16, 32'sd0, 1'b0, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_LOAD, 32'sd2 <<< 16, 32'sd1 <<< 16, 1'b0, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_LOAD, 32'sd3 <<< 16, 32'sd3 <<< 16, 1'b1, 32'sd0));
    send_item(make_req(crarc_pkg::CMD_POS, 32'sd0, 32'sd0, 1'b0, 32'sd1 <<< 15));
    send_item(make_req(crarc_pkg::CMD_TAN, 32'sd0, 32'sd0, 1'b0, 32'sd1 <<< 15));
    send_item(make_req(crarc_pkg::CMD_POS, 32'sd0, 32'sd0, 1'b0, -(32'sd1 <<< 16)));
    path_scale = 17;
    path_pts = 4;
    loads_closed += 3;

    // Random phases, each under its own step count and idling pattern.
    write_steps(11'd4);
    idle_pct = 0;
    stall_pct = 0;
    run_traffic(300, 1'b0);

    write_steps(11'd0);
    idle_pct = 70;
    stall_pct = 0;
    run_traffic(300, 1'b0);

    write_steps(11'($urandom_range(2, 8)));
    idle_pct = 0;
    stall_pct = 70;
    run_traffic(300, 1'b0);

    write_steps(11'd1);
    idle_pct = 37;
    stall_pct = 37;
    run_traffic(300, 1'b1);

    // The largest register value is clipped to the maximum step count; a
    // single segment keeps the long build affordable.
    write_steps(11'h7FF);
    idle_pct = 0;
    stall_pct = 0;
    load_path(4, $urandom_range(8, 31));
    repeat (12) send_query();

    write_steps(11'($urandom_range(1, 8)));
    idle_pct = 37;
    stall_pct = 37;
    run_traffic(300, 1'b0);

    // Finish on a query so that any build still running has completed.
    wait_idle();
    repeat (200) @(posedge clk);

    $display("Covered %0d request items, %0d closed paths and %0d checked answers",
             items_sent, loads_closed, answered);
    $display("over %0d step count settings with idling on both channels.", settings_used + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
